[rtl/pscc_pkg.sv]
`default_nettype none

package pscc_pkg;

  // Packet framing
  localparam int unsigned PACKET_BYTES   = 2048;
  localparam int unsigned HEADER_LEN_POS = 22;
  localparam int unsigned POS_W          = $clog2(PACKET_BYTES);

  // Field widths
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned COUNT_W = 11;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Payload start is HEADER_LEN_POS + 1 + length, up to 22 + 1 + 255 + 3 with margin
  localparam int unsigned LIMIT_W = ((POS_W > 9) ? POS_W : 9) + 1;

  // Picture start code 00 00 01 00 and an idle history that never matches
  localparam logic [4*DATA_W-1:0] PIC_CODE   = 32'h0000_0100;
  localparam logic [3*DATA_W-1:0] TAIL_RESET = 24'hFF_FFFF;

  // Queue between front and back
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              payload;  // byte belongs to the payload
    logic              early;    // within the first three payload bytes
    logic              last;     // last byte of the packet
  } item_t;

  typedef struct packed {
    logic  push;
    item_t item;
  } push_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

endpackage

`default_nettype wire

[rtl/pscc_byte_if.sv]
`default_nettype none

interface pscc_byte_if
  import pscc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

[rtl/pscc_result_if.sv]
`default_nettype none

interface pscc_result_if
  import pscc_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] picture_count;
  logic               split_seen;

  modport source (output valid, output picture_count, output split_seen, input ready);
  modport sink   (input valid, input picture_count, input split_seen, output ready);
endinterface

`default_nettype wire

[rtl/pscc_front.sv]
`default_nettype none

module pscc_front
  import pscc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  pscc_byte_if.sink   byte_i,
  input  logic        full_i,
  output push_t       push_o
);

  logic [POS_W-1:0]   pos_q, pos_d;
  logic [DATA_W-1:0]  hdr_q, hdr_d;
  logic [LIMIT_W-1:0] pos_ext;
  logic [LIMIT_W-1:0] start;
  logic [LIMIT_W-1:0] early_end;
  logic               accept;
  logic               is_hdr_pos;
  logic               is_last;

  assign byte_i.ready = !full_i;
  assign accept       = byte_i.valid && !full_i;

  assign pos_ext    = LIMIT_W'(pos_q);
  assign start      = LIMIT_W'(HEADER_LEN_POS + 1) + LIMIT_W'(hdr_q);
  assign early_end  = start + LIMIT_W'(3);
  assign is_hdr_pos = (pos_q == POS_W'(HEADER_LEN_POS));
  assign is_last    = (pos_q == POS_W'(PACKET_BYTES - 1));

  always_comb begin
    push_o.push         = accept;
    push_o.item.data    = byte_i.data_byte;
    push_o.item.payload = (pos_ext > LIMIT_W'(HEADER_LEN_POS)) && (pos_ext >= start);
    push_o.item.early   = (pos_ext < early_end);
    push_o.item.last    = is_last;
  end

  always_comb begin
    pos_d = pos_q;
    hdr_d = hdr_q;
    if (accept) begin
      if (is_hdr_pos) begin
        hdr_d = byte_i.data_byte;
      end
      if (is_last) begin
        pos_d = '0;
      end else begin
        pos_d = pos_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      hdr_q <= '0;
    end else begin
      pos_q <= pos_d;
      hdr_q <= hdr_d;
    end
  end

endmodule

`default_nettype wire

[rtl/pscc_fifo.sv]
`default_nettype none

module pscc_fifo
  import pscc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  input  logic  pop_i,
  output logic  full_o,
  output head_t head_o
);

  item_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_PTR_W:0]   cnt_q;
  logic                  do_push, do_pop;

  assign full_o      = (cnt_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];

  assign do_push = push_i.push && !full_o;
  assign do_pop  = pop_i && head_o.valid;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (FIFO_PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (FIFO_PTR_W+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/pscc_back.sv]
`default_nettype none

module pscc_back
  import pscc_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  head_t         head_i,
  output logic          pop_o,
  pscc_result_if.source result_o
);

  logic [3*DATA_W-1:0] tail_q, tail_d;
  logic [COUNT_W-1:0]  count_q, count_d;
  logic                split_q, split_d;
  logic                out_valid_q, out_valid_d;
  logic [COUNT_W-1:0]  out_count_q, out_count_d;
  logic                out_split_q, out_split_d;
  logic                out_free;
  logic [4*DATA_W-1:0] window;
  logic                hit;
  logic [COUNT_W-1:0]  count_upd;
  logic                split_upd;

  assign out_free = !out_valid_q || result_o.ready;
  // A last byte waits until the result register can take the packet's total
  assign pop_o    = head_i.valid && (!head_i.item.last || out_free);

  assign window = {tail_q, head_i.item.data};
  assign hit    = head_i.item.payload && (window == PIC_CODE);

  always_comb begin
    count_upd = count_q;
    split_upd = split_q;
    if (hit) begin
      if (count_q != COUNT_MAX) begin
        count_upd = count_q + COUNT_W'(1);
      end
      if (head_i.item.early) begin
        split_upd = 1'b1;
      end
    end
  end

  always_comb begin
    tail_d      = tail_q;
    count_d     = count_q;
    split_d     = split_q;
    out_valid_d = out_valid_q && !result_o.ready;
    out_count_d = out_count_q;
    out_split_d = out_split_q;
    if (pop_o) begin
      if (head_i.item.payload) begin
        tail_d = window[3*DATA_W-1:0];
      end
      if (head_i.item.last) begin
        out_valid_d = 1'b1;
        out_count_d = count_upd;
        out_split_d = split_upd;
        count_d     = '0;
        split_d     = 1'b0;
      end else begin
        count_d = count_upd;
        split_d = split_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_q      <= TAIL_RESET;
      count_q     <= '0;
      split_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      tail_q      <= tail_d;
      count_q     <= count_d;
      split_q     <= split_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_count_q <= out_count_d;
    out_split_q <= out_split_d;
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.picture_count = out_count_q;
  assign result_o.split_seen    = out_split_q;

endmodule

`default_nettype wire

[rtl/picture_start_code_counter_core.sv]
// Picture start code counter. Takes one stream byte per clock on byte_i and
// counts picture start codes (00 00 01 00, overlaps included) in the payload
// of each fixed-size packet of PACKET_BYTES bytes; the byte at HEADER_LEN_POS
// gives the header-data length and the payload starts right after the header.
// The last three payload bytes carry over to the next packet, so a code split
// across a boundary counts in the packet where it completes and sets
// split_seen. One result per packet is registered on result_o as the
// packet's last byte leaves the queue, later only while an earlier result
// still waits there; the count saturates at 2047. While the queue has room the
// rate is one byte per clock: the front classifier and the back matcher each
// handle a byte every cycle, joined by a four-entry queue. Input ready drops
// only when that queue fills, which happens only while a finished result is
// still held at result_o and the next packet's last byte has arrived.
`default_nettype none

module picture_start_code_counter_core
  import pscc_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  pscc_byte_if.sink     byte_i,
  pscc_result_if.source result_o
);

  push_t push;     // classified beat from the front
  head_t head;     // oldest queued beat for the back
  logic  full;
  logic  pop;

  // Front: track packet position and header length, tag each beat
  pscc_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_i),
    .full_i (full),
    .push_o (push)
  );

  // Decouple classification from matching so each side stalls alone
  pscc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .full_o (full),
    .head_o (head)
  );

  // Back: shift payload history, match, count, and hold the packet result
  pscc_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .pop_o    (pop),
    .result_o (result_o)
  );

endmodule

`default_nettype wire

[rtl/pscc_checker.sv]
`default_nettype none

module pscc_checker
  import pscc_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [COUNT_W-1:0] out_count_i,
  input logic               out_split_i
);

  logic [POS_W-1:0] pos_q;
  logic [2:0]       pending_q;
  logic             in_fire, out_fire, pkt_done;

  assign in_fire  = in_valid_i && in_ready_i;
  assign out_fire = out_valid_i && out_ready_i;
  assign pkt_done = in_fire && (pos_q == POS_W'(PACKET_BYTES - 1));

  // Track packets completed at the input but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      pending_q <= '0;
    end else begin
      if (in_fire) begin
        pos_q <= pkt_done ? '0 : pos_q + POS_W'(1);
      end
      if (pkt_done && !out_fire) begin
        pending_q <= pending_q + 3'd1;
      end else if (out_fire && !pkt_done) begin
        pending_q <= pending_q - 3'd1;
      end
    end
  end

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_count_i)
      && $stable(out_split_i))
    else $error("result changed while stalled");

  a_split_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_split_i |-> out_count_i != '0)
    else $error("split flag without a counted code");

  a_no_extra_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != '0)
    else $error("result without a completed packet");

  a_bounded_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd2)
    else $error("too many undelivered packets");

endmodule

bind picture_start_code_counter_core pscc_checker u_pscc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (byte_i.valid),
  .in_ready_i  (byte_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_count_i (result_o.picture_count),
  .out_split_i (result_o.split_seen)
);

`default_nettype wire

[tb/pscc_count_check.sv]
`timescale 1ns / 1ps

module pscc_count_check
  import pscc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               byte_valid_i,
  input  logic               byte_ready_i,
  input  logic [DATA_W-1:0]  data_byte_i,
  input  logic               result_valid_i,
  input  logic               result_ready_i,
  input  logic [COUNT_W-1:0] picture_count_i,
  input  logic               split_seen_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               split;
  } pic_result_t;

  logic [POS_W-1:0]      pkt_pos;
  logic [DATA_W-1:0]     hdr_len;
  logic [3*DATA_W-1:0]   payload_tail;
  logic [COUNT_W-1:0]    pic_count;
  logic                  split_hit;
  pic_result_t           packet_results_q[$];

  always @(posedge clk_i or negedge rst_ni) begin : track
    int unsigned         payload_first;
    logic [4*DATA_W-1:0] window;
    pic_result_t         want;

    if (!rst_ni) begin
      pkt_pos      = '0;
      hdr_len      = '0;
      payload_tail = TAIL_RESET;
      pic_count    = '0;
      split_hit    = 1'b0;
      packet_results_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // Check the outgoing beat first: a result never leaves on the edge
      // that closes its own packet.
      if (result_valid_i && result_ready_i) begin
        if (packet_results_q.size() == 0) begin
          $error("result beat with no packet result due: picture_count %0d, split_seen %0d",
                 picture_count_i, split_seen_i);
          fail_count_o++;
        end else begin
          want = packet_results_q.pop_front();
          if (picture_count_i !== want.count) begin
            $error("picture_count mismatch: expected %0d, actual %0d",
                   want.count, picture_count_i);
            fail_count_o++;
          end
          if (split_seen_i !== want.split) begin
            $error("split_seen mismatch: expected %0d, actual %0d",
                   want.split, split_seen_i);
            fail_count_o++;
          end
        end
      end

      if (byte_valid_i && byte_ready_i) begin
        if (pkt_pos == HEADER_LEN_POS) hdr_len = data_byte_i;
        payload_first = HEADER_LEN_POS + 1 + hdr_len;
        // Only payload bytes enter the history and can complete a code
        if (pkt_pos > HEADER_LEN_POS && pkt_pos >= payload_first) begin
          window = {payload_tail, data_byte_i};
          if (window == PIC_CODE) begin
            if (pic_count != COUNT_MAX) pic_count = pic_count + 1'b1;
            if (pkt_pos < payload_first + 3) split_hit = 1'b1;
          end
          payload_tail = window[3*DATA_W-1:0];
        end
        if (pkt_pos == PACKET_BYTES - 1) begin
          want.count = pic_count;
          want.split = split_hit;
          packet_results_q.push_back(want);
          pic_count = '0;
          split_hit = 1'b0;
          pkt_pos   = '0;
        end else begin
          pkt_pos = pkt_pos + 1'b1;
        end
      end

      pending_o = packet_results_q.size();
    end
  end

endmodule

[tb/picture_start_code_counter_core_test.sv]
`timescale 1ns / 1ps

module picture_start_code_counter_core_test;
  import pscc_pkg::*;

  // Several dozen packet results; each packet is a full PACKET_BYTES frame.
  localparam int RANDOM_PACKETS  = 40;
  localparam int CYCLE_LIMIT     = 2_000_000;
  localparam int HOLD_OFF_CYCLES = 9000;
  localparam int DRAIN_CYCLES    = 20;

  // Payload content styles
  typedef enum int {
    FILL_NOISE,   // uniform random bytes
    FILL_DENSE,   // mostly 00 and 01, codes appear by chance
    FILL_CODES,   // random bytes with planted runs of overlapping codes
    FILL_ZERO,    // all zero, never a match
    FILL_RUN      // 00 00 01 repeated, densest overlap
  } fill_e;

  logic clk = 1'b0;
  logic rst_n;

  pscc_byte_if   byte_ch();
  pscc_result_if pic_ch();

  logic [DATA_W-1:0] pkt_bytes [PACKET_BYTES];

  int carry_len;      // code bytes left hanging at the end of the last payload
  int burst_left;
  int bytes_sent;
  int cycle_count;
  int fail_count;
  int pending_count;

  always #1 clk = ~clk;

  picture_start_code_counter_core dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .byte_i   (byte_ch),
    .result_o (pic_ch)
  );

  pscc_count_check u_count_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .byte_valid_i    (byte_ch.valid),
    .byte_ready_i    (byte_ch.ready),
    .data_byte_i     (byte_ch.data_byte),
    .result_valid_i  (pic_ch.valid),
    .result_ready_i  (pic_ch.ready),
    .picture_count_i (pic_ch.picture_count),
    .split_seen_i    (pic_ch.split_seen),
    .fail_count_o    (fail_count),
    .pending_o       (pending_count)
  );

  // Byte idx of the picture start code, MSB first
  function automatic logic [DATA_W-1:0] code_byte(input int idx);
    return PIC_CODE[DATA_W*(3-idx) +: DATA_W];
  endfunction

  // Offer one beat. Enter and leave at a falling edge. Between bursts drop
  // valid for a random gap and scramble the idle data.
  task automatic send_byte(input logic [DATA_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      byte_ch.valid     <= 1'b0;
      byte_ch.data_byte <= DATA_W'($urandom_range(0, 255));
      repeat (gap) @(negedge clk);
      // Mostly short bursts; now and then a long stretch with no idling
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(500, 4000)
                                               : $urandom_range(4, 40);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    burst_left--;
    bytes_sent++;
    @(negedge clk);
  endtask

  // Build one packet in pkt_bytes. The header region (including the
  // header-data bytes) is either noise or stuffed with start codes, which
  // must never count. A code left hanging by the previous payload is
  // completed at the head of this payload; plant_len bytes of a new code
  // are left hanging at the end of this one.
  task automatic build_packet(input fill_e fill, input logic [DATA_W-1:0] len,
                              input bit hdr_codes, input int plant_len);
    int first;
    int run_left;
    int run_pos;
    first    = HEADER_LEN_POS + 1 + len;
    run_left = 0;
    run_pos  = 0;
    for (int i = 0; i < PACKET_BYTES; i++) begin
      if (i < first) begin
        pkt_bytes[i] = hdr_codes ? code_byte(i % 4) : DATA_W'($urandom_range(0, 255));
      end else begin
        case (fill)
          FILL_NOISE: pkt_bytes[i] = DATA_W'($urandom_range(0, 255));
          FILL_DENSE: begin
            case ($urandom_range(0, 9))
              0, 1, 2, 3, 4: pkt_bytes[i] = code_byte(0);
              5, 6, 7:       pkt_bytes[i] = code_byte(2);
              default:       pkt_bytes[i] = DATA_W'($urandom_range(0, 255));
            endcase
          end
          FILL_CODES: begin
            // Runs of 3n+1 bytes hold n overlapping codes
            if (run_left == 0 && $urandom_range(0, 7) == 0) begin
              run_left = 4 + 3 * $urandom_range(0, 3);
              run_pos  = 0;
            end
            if (run_left != 0) begin
              pkt_bytes[i] = (run_pos % 3 == 2) ? code_byte(2) : code_byte(0);
              run_pos++;
              run_left--;
            end else begin
              pkt_bytes[i] = DATA_W'($urandom_range(0, 255));
            end
          end
          FILL_ZERO: pkt_bytes[i] = code_byte(0);
          default:   pkt_bytes[i] = ((i - first) % 3 == 2) ? code_byte(2) : code_byte(0);
        endcase
      end
    end
    pkt_bytes[HEADER_LEN_POS] = len;
    // Complete a code split over the boundary
    if (carry_len != 0) begin
      for (int k = 0; k < 4 - carry_len; k++) pkt_bytes[first + k] = code_byte(carry_len + k);
    end
    // Hang a code prefix at the very end of the payload
    for (int k = 0; k < plant_len; k++) begin
      pkt_bytes[PACKET_BYTES - plant_len + k] = code_byte(k);
    end
    carry_len = plant_len;
  endtask

  task automatic send_packet(input fill_e fill, input logic [DATA_W-1:0] len,
                             input bit hdr_codes, input int plant_len);
    build_packet(fill, len, hdr_codes, plant_len);
    for (int i = 0; i < PACKET_BYTES; i++) send_byte(pkt_bytes[i]);
  endtask

  // Result side: stall on a rotating 13-bit mask, redrawn each turn and
  // sometimes all ones. Twice, hold off for a long stretch while the sender
  // keeps going, so two finished packets back up and the input stalls.
  initial begin : result_sink
    int          hold_left;
    int          holds_done;
    int          phase;
    logic [12:0] ready_mask;
    hold_left  = 0;
    holds_done = 0;
    phase      = 0;
    ready_mask = '1;
    pic_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 &&
          ((holds_done == 0 && bytes_sent >= 4 * PACKET_BYTES) ||
           (holds_done == 1 && bytes_sent >= 24 * PACKET_BYTES))) begin
        hold_left = HOLD_OFF_CYCLES;
        holds_done++;
      end
      if (hold_left != 0) begin
        hold_left--;
        pic_ch.ready <= 1'b0;
      end else begin
        if (phase == 0) begin
          ready_mask = ($urandom_range(0, 2) == 0) ? '1 : 13'($urandom);
        end
        pic_ch.ready <= ready_mask[phase];
        phase = (phase == 12) ? 0 : phase + 1;
      end
    end
  end

  // Watchdog: stop a hung run
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("picture_start_code_counter_core test failed");
    $finish;
  end

  initial begin : stimulus
    fill_e              fill;
    logic [DATA_W-1:0]  len;
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = '0;
    rst_n             = 1'b0;
    carry_len         = 0;
    burst_left        = 0;
    bytes_sent        = 0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Directed packets: shortest and longest header, all-zero payload,
    // header stuffed with codes, densest overlap, codes split across
    // the boundary after one, two and three of their bytes.
    send_packet(FILL_ZERO,  8'd0,   1'b0, 0);
    send_packet(FILL_RUN,   8'd255, 1'b1, 3);
    send_packet(FILL_CODES, 8'd17,  1'b1, 2);
    send_packet(FILL_NOISE, 8'd0,   1'b0, 1);
    send_packet(FILL_DENSE, 8'd128, 1'b0, 0);
    send_packet(FILL_RUN,   8'd1,   1'b1, 1);
    send_packet(FILL_NOISE, 8'd255, 1'b0, 0);

    // Random packets, weighted toward code-rich payloads
    for (int p = 0; p < RANDOM_PACKETS; p++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3:                  fill = FILL_NOISE;
        4, 5, 6, 7, 8, 9, 10:        fill = FILL_DENSE;
        11, 12, 13, 14, 15, 16, 17:  fill = FILL_CODES;
        18:                          fill = FILL_ZERO;
        default:                     fill = FILL_RUN;
      endcase
      case ($urandom_range(0, 5))
        0:       len = '0;
        1:       len = '1;
        2:       len = DATA_W'($urandom_range(1, 3));
        default: len = DATA_W'($urandom_range(0, 255));
      endcase
      send_packet(fill, len, $urandom_range(0, 3) == 0,
                  $urandom_range(0, 1) ? $urandom_range(1, 3) : 0);
    end
    byte_ch.valid <= 1'b0;

    // Drain the outstanding results, then give stray beats time to show
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("picture_start_code_counter_core test passed");
    end else begin
      $display("picture_start_code_counter_core test failed");
    end
    $finish;
  end

endmodule
